@@ rtl/core/pvu_pkg.sv @@
// shared types and constants for the particle velocity and position update unit
package pvu_pkg;

  // fixed-point format of positions and speeds
  localparam int FRAC_BITS = 16;

  // wall margin of 0.01, rounded down to the raw grid
  localparam logic [31:0] WALL_MARGIN = 32'((1 << FRAC_BITS) / 100);

  // register file geometry
  localparam int ADDR_W = 5;

  // register indexes, word addressed
  typedef enum logic [2:0] {
    REG_GRAVITY = 3'd0,
    REG_RADIUS  = 3'd1,
    REG_ROOM    = 3'd2,
    REG_ATT_X   = 3'd3,
    REG_ATT_Y   = 3'd4,
    REG_HALF    = 3'd5,
    REG_MODE    = 3'd6
  } reg_idx_t;

  // settings handed from the register block to the datapath
  typedef struct packed {
    logic        [15:0] gravity;
    logic signed [31:0] att_x;
    logic signed [31:0] att_y;
    logic        [25:0] half;
    logic signed [4:0]  mode;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] lo_m;
    logic signed [31:0] hi_m;
  } cfg_t;

endpackage

@@ rtl/core/particle_velocity_position_update_unit.sv @@
// top level: six-stage euler step pipeline for one particle per beat
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+---------------------------------------------
//  in      | input     | in_valid/ready   | pos_x, pos_y, speed_x, speed_y
//  out     | output    | out_valid/ready  | new_pos/speed x,y, wall_hit x,y
//  cfg     | input     | psel/penable     | paddr, pwdata, prdata (pready tied high)
//
// one beat per cycle sustained while out is not stalled; each beat passes
// through the six register stages (gravity/offset, box test/product,
// attraction add, damping, position add, wall clamp into the output register).
// rst_n is synchronous and clears the stage valid bits; data registers keep no reset.
// a stall on out holds full stages and bubbles are squeezed out behind it.
module particle_velocity_position_update_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_pos_x,
  input  logic signed [31:0]          in_pos_y,
  input  logic signed [31:0]          in_speed_x,
  input  logic signed [31:0]          in_speed_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_new_pos_x,
  output logic signed [31:0]          out_new_pos_y,
  output logic signed [31:0]          out_new_speed_x,
  output logic signed [31:0]          out_new_speed_y,
  output logic                        out_wall_hit_x,
  output logic                        out_wall_hit_y,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pvu_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int NSTG = 6;

  pvu_pkg::cfg_t cfg;

  pvu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage control
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] ld;

  always_comb begin
    ld[NSTG-1] = ~v_r[NSTG-1] | out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      ld[i] = ~v_r[i] | ld[i+1];
    end
    v_nxt[0] = ld[0] ? in_valid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      v_nxt[i] = ld[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = v_r[NSTG-1];

  // stage 0: gravity and attractor offsets
  logic signed [31:0] s0_px_r, s0_py_r, s0_sx_r, s0_sy_r, s0_dx_r, s0_dy_r;
  logic signed [31:0] s0_sy_nxt, s0_dx_nxt, s0_dy_nxt;

  assign s0_sy_nxt = in_speed_y - $signed({16'd0, cfg.gravity});
  assign s0_dx_nxt = cfg.att_x - in_pos_x;
  assign s0_dy_nxt = cfg.att_y - in_pos_y;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s0_px_r <= in_pos_x;
      s0_py_r <= in_pos_y;
      s0_sx_r <= in_speed_x;
      s0_sy_r <= s0_sy_nxt;
      s0_dx_r <= s0_dx_nxt;
      s0_dy_r <= s0_dy_nxt;
    end
  end

  // stage 1: box test and attraction products
  logic signed [31:0] s1_px_r, s1_py_r, s1_sx_r, s1_sy_r, s1_ax_r, s1_ay_r;
  logic               s1_en_r;
  logic signed [31:0] half_s, half_neg;
  logic               s1_en_nxt;
  logic signed [36:0] prod_x, prod_y;

  assign half_s   = $signed({6'd0, cfg.half});
  assign half_neg = -half_s;
  assign s1_en_nxt = (cfg.mode != 5'sd0)
                   && (s0_dx_r >= half_neg) && (s0_dx_r <= half_s)
                   && (s0_dy_r >= half_neg) && (s0_dy_r <= half_s);
  assign prod_x = (s0_dx_r >>> 4) * cfg.mode;
  assign prod_y = (s0_dy_r >>> 4) * cfg.mode;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      s1_px_r <= s0_px_r;
      s1_py_r <= s0_py_r;
      s1_sx_r <= s0_sx_r;
      s1_sy_r <= s0_sy_r;
      s1_ax_r <= prod_x[31:0];
      s1_ay_r <= prod_y[31:0];
      s1_en_r <= s1_en_nxt;
    end
  end

  // stage 2: attraction add
  logic signed [31:0] s2_px_r, s2_py_r, s2_sx_r, s2_sy_r;
  logic signed [31:0] s2_sx_nxt, s2_sy_nxt;

  assign s2_sx_nxt = s1_en_r ? s1_sx_r + s1_ax_r : s1_sx_r;
  assign s2_sy_nxt = s1_en_r ? s1_sy_r + s1_ay_r : s1_sy_r;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      s2_px_r <= s1_px_r;
      s2_py_r <= s1_py_r;
      s2_sx_r <= s2_sx_nxt;
      s2_sy_r <= s2_sy_nxt;
    end
  end

  // stage 3: damping
  logic signed [31:0] s3_px_r, s3_py_r, s3_sx_r, s3_sy_r;
  logic signed [31:0] s3_sx_nxt, s3_sy_nxt;

  assign s3_sx_nxt = s2_sx_r - (s2_sx_r >>> 11);
  assign s3_sy_nxt = s2_sy_r - (s2_sy_r >>> 11);

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      s3_px_r <= s2_px_r;
      s3_py_r <= s2_py_r;
      s3_sx_r <= s3_sx_nxt;
      s3_sy_r <= s3_sy_nxt;
    end
  end

  // stage 4: position update
  logic signed [31:0] s4_px_r, s4_py_r, s4_sx_r, s4_sy_r;
  logic signed [31:0] s4_px_nxt, s4_py_nxt;

  assign s4_px_nxt = s3_px_r + (s3_sx_r >>> 8);
  assign s4_py_nxt = s3_py_r + (s3_sy_r >>> 8);

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      s4_px_r <= s4_px_nxt;
      s4_py_r <= s4_py_nxt;
      s4_sx_r <= s3_sx_r;
      s4_sy_r <= s3_sy_r;
    end
  end

  // stage 5: wall clamp into the output register, high wall checked first
  logic signed [31:0] px_nxt, py_nxt, sx_nxt, sy_nxt;
  logic               hx_nxt, hy_nxt;
  logic signed [31:0] out_px_r, out_py_r, out_sx_r, out_sy_r;
  logic               out_hx_r, out_hy_r;

  always_comb begin
    px_nxt = s4_px_r;
    sx_nxt = s4_sx_r;
    hx_nxt = 1'b0;
    if (s4_px_r > cfg.hi) begin
      px_nxt = cfg.hi_m;
      sx_nxt = 32'sd0;
      hx_nxt = 1'b1;
    end else if (s4_px_r < cfg.lo) begin
      px_nxt = cfg.lo_m;
      sx_nxt = 32'sd0;
      hx_nxt = 1'b1;
    end
    py_nxt = s4_py_r;
    sy_nxt = s4_sy_r;
    hy_nxt = 1'b0;
    if (s4_py_r > cfg.hi) begin
      py_nxt = cfg.hi_m;
      sy_nxt = 32'sd0;
      hy_nxt = 1'b1;
    end else if (s4_py_r < cfg.lo) begin
      py_nxt = cfg.lo_m;
      sy_nxt = 32'sd0;
      hy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      out_px_r <= px_nxt;
      out_py_r <= py_nxt;
      out_sx_r <= sx_nxt;
      out_sy_r <= sy_nxt;
      out_hx_r <= hx_nxt;
      out_hy_r <= hy_nxt;
    end
  end

  assign out_new_pos_x   = out_px_r;
  assign out_new_pos_y   = out_py_r;
  assign out_new_speed_x = out_sx_r;
  assign out_new_speed_y = out_sy_r;
  assign out_wall_hit_x  = out_hx_r;
  assign out_wall_hit_y  = out_hy_r;

endmodule

@@ rtl/core/pvu_cfg.sv @@
// register block with apb-style access and derived wall limits
module pvu_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pvu_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output pvu_pkg::cfg_t               cfg
);

  logic        [15:0] gravity_r;
  logic        [30:0] radius_r;
  logic        [30:0] room_r;
  logic        [31:0] att_x_r;
  logic        [31:0] att_y_r;
  logic        [25:0] half_r;
  logic        [4:0]  mode_r;
  logic        [2:0]  idx;
  logic               wr_en;
  logic        [31:0] hi;

  assign pready = 1'b1;
  assign idx    = paddr[pvu_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r <= 16'd0;
      radius_r  <= 31'd32768;
      room_r    <= 31'd4194304;
      att_x_r   <= 32'd0;
      att_y_r   <= 32'd0;
      half_r    <= 26'd1966080;
      mode_r    <= 5'd0;
    end else if (wr_en) begin
      case (idx)
        pvu_pkg::REG_GRAVITY: gravity_r <= pwdata[15:0];
        pvu_pkg::REG_RADIUS:  radius_r  <= pwdata[30:0];
        pvu_pkg::REG_ROOM:    room_r    <= pwdata[30:0];
        pvu_pkg::REG_ATT_X:   att_x_r   <= pwdata;
        pvu_pkg::REG_ATT_Y:   att_y_r   <= pwdata;
        pvu_pkg::REG_HALF:    half_r    <= pwdata[25:0];
        pvu_pkg::REG_MODE:    mode_r    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      pvu_pkg::REG_GRAVITY: prdata = {16'd0, gravity_r};
      pvu_pkg::REG_RADIUS:  prdata = {1'b0, radius_r};
      pvu_pkg::REG_ROOM:    prdata = {1'b0, room_r};
      pvu_pkg::REG_ATT_X:   prdata = att_x_r;
      pvu_pkg::REG_ATT_Y:   prdata = att_y_r;
      pvu_pkg::REG_HALF:    prdata = {6'd0, half_r};
      pvu_pkg::REG_MODE:    prdata = {{27{mode_r[4]}}, mode_r};
      default:              prdata = 32'd0;
    endcase
  end

  // wall limits, all with 32-bit wrap
  assign hi = {1'b0, room_r} - {1'b0, radius_r};

  always_comb begin
    cfg.gravity = gravity_r;
    cfg.att_x   = att_x_r;
    cfg.att_y   = att_y_r;
    cfg.half    = half_r;
    cfg.mode    = mode_r;
    cfg.lo      = {1'b0, radius_r};
    cfg.hi      = hi;
    cfg.lo_m    = {1'b0, radius_r} + pvu_pkg::WALL_MARGIN;
    cfg.hi_m    = hi - pvu_pkg::WALL_MARGIN;
  end

endmodule

@@ rtl/core/pvu_checker.sv @@
// port-level checks for the particle update unit, bound to the top level
module pvu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_new_pos_x,
  input logic signed [31:0] out_new_pos_y,
  input logic signed [31:0] out_new_speed_x,
  input logic signed [31:0] out_new_speed_y,
  input logic               out_wall_hit_x,
  input logic               out_wall_hit_y
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_new_pos_x) && $stable(out_new_pos_y)
      && $stable(out_new_speed_x) && $stable(out_new_speed_y)
      && $stable(out_wall_hit_x) && $stable(out_wall_hit_y))
    else $error("result payload changed while stalled");

  // a wall hit on x zeroes the x speed
  a_hit_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wall_hit_x |-> out_new_speed_x == 32'sd0)
    else $error("x speed not zeroed after wall hit");

  // a wall hit on y zeroes the y speed
  a_hit_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wall_hit_y |-> out_new_speed_y == 32'sd0)
    else $error("y speed not zeroed after wall hit");

  // with no result pending the pipeline cannot be full
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind particle_velocity_position_update_unit pvu_checker u_pvu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_new_pos_x   (out_new_pos_x),
  .out_new_pos_y   (out_new_pos_y),
  .out_new_speed_x (out_new_speed_x),
  .out_new_speed_y (out_new_speed_y),
  .out_wall_hit_x  (out_wall_hit_x),
  .out_wall_hit_y  (out_wall_hit_y)
);

@@ test/tb_top.sv @@
// testbench for the particle velocity and position update unit: directed and random beats
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // one updated particle as the block should return it
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] spd_x;
    logic signed [31:0] spd_y;
    logic               hit_x;
    logic               hit_y;
  } particle_t;

  // one axis after the wall clamp
  typedef struct packed {
    logic signed [31:0] pos;
    logic signed [31:0] spd;
    logic               hit;
  } axis_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_speed_x = '0;
  logic signed [31:0] in_speed_y = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_new_pos_x;
  logic signed [31:0] out_new_pos_y;
  logic signed [31:0] out_new_speed_x;
  logic signed [31:0] out_new_speed_y;
  logic               out_wall_hit_x;
  logic               out_wall_hit_y;

  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [pvu_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  // shadow copy of the register file, reset values
  logic [15:0]        gravity_cfg = 16'd0;
  logic [30:0]        radius_cfg  = 31'd32768;
  logic [30:0]        room_cfg    = 31'd4194304;
  logic signed [31:0] att_x_cfg   = 32'sd0;
  logic signed [31:0] att_y_cfg   = 32'sd0;
  logic [25:0]        half_cfg    = 26'd1966080;
  logic signed [4:0]  mode_cfg    = 5'sd0;

  particle_t pending_updates[$];
  int        mismatch_count = 0;
  int        send_style = 1;
  int        recv_style = 1;
  int        hold_request = 0;

  particle_velocity_position_update_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_speed_x      (in_speed_x),
    .in_speed_y      (in_speed_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_new_pos_x   (out_new_pos_x),
    .out_new_pos_y   (out_new_pos_y),
    .out_new_speed_x (out_new_speed_x),
    .out_new_speed_y (out_new_speed_y),
    .out_wall_hit_x  (out_wall_hit_x),
    .out_wall_hit_y  (out_wall_hit_y),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // clamp one axis against the low and high walls, high wall first
  function automatic axis_t wall_clamp(input logic signed [31:0] p, input logic signed [31:0] s);
    logic signed [31:0] lo_wall;
    logic signed [31:0] hi_wall;
    axis_t              r;
    lo_wall = {1'b0, radius_cfg};
    hi_wall = {1'b0, room_cfg} - lo_wall;
    r.pos = p;
    r.spd = s;
    r.hit = 1'b0;
    if (p > hi_wall) begin
      r.pos = hi_wall - pvu_pkg::WALL_MARGIN;
      r.spd = '0;
      r.hit = 1'b1;
    end else if (p < lo_wall) begin
      r.pos = lo_wall + pvu_pkg::WALL_MARGIN;
      r.spd = '0;
      r.hit = 1'b1;
    end
    return r;
  endfunction

  // one euler step: gravity, attraction, damping, move, walls
  function automatic particle_t euler_step(input logic signed [31:0] px0, input logic signed [31:0] py0,
                                           input logic signed [31:0] sx0, input logic signed [31:0] sy0);
    logic signed [31:0] px, py, sx, sy;
    logic signed [31:0] dx, dy, gain, half_s, nhalf;
    axis_t              ax, ay;
    particle_t          r;
    px = px0;
    py = py0;
    sx = sx0;
    sy = sy0 - {16'd0, gravity_cfg};
    gain = 32'(mode_cfg);
    if (mode_cfg != 5'sd0) begin
      dx = att_x_cfg - px;
      dy = att_y_cfg - py;
      half_s = {6'd0, half_cfg};
      nhalf = -half_s;
      if (dx >= nhalf && dx <= half_s && dy >= nhalf && dy <= half_s) begin
        sx = sx + (dx >>> 4) * gain;
        sy = sy + (dy >>> 4) * gain;
      end
    end
    sx = sx - (sx >>> 11);
    sy = sy - (sy >>> 11);
    px = px + (sx >>> 8);
    py = py + (sy >>> 8);
    ax = wall_clamp(px, sx);
    ay = wall_clamp(py, sy);
    r.pos_x = ax.pos;
    r.pos_y = ay.pos;
    r.spd_x = ax.spd;
    r.spd_y = ay.spd;
    r.hit_x = ax.hit;
    r.hit_y = ay.hit;
    return r;
  endfunction

  // idle cycles before a beat: none, occasional, or heavy
  function automatic int idle_cycles(input int style);
    case (style)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
      default: return int'($urandom_range(0, 12));
    endcase
  endfunction

  // value around a center, wrapping
  function automatic logic [31:0] near(input logic [31:0] c, input logic [31:0] span);
    return c + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic logic [31:0] in_room();
    return $urandom_range(0, room_cfg) + $urandom_range(0, 8192) - 32'd4096;
  endfunction

  function automatic logic [31:0] random_speed();
    case ($urandom_range(0, 9))
      0:             return $urandom;
      1, 2, 3, 4, 5: return near(32'd0, 32'd1 << 20);
      default:       return near(32'd0, 32'd1 << 27);
    endcase
  endfunction

  // register value as a read should return it
  function automatic logic [31:0] shadow_read(input pvu_pkg::reg_idx_t idx);
    case (idx)
      pvu_pkg::REG_GRAVITY: return {16'd0, gravity_cfg};
      pvu_pkg::REG_RADIUS:  return {1'b0, radius_cfg};
      pvu_pkg::REG_ROOM:    return {1'b0, room_cfg};
      pvu_pkg::REG_ATT_X:   return att_x_cfg;
      pvu_pkg::REG_ATT_Y:   return att_y_cfg;
      pvu_pkg::REG_HALF:    return {6'd0, half_cfg};
      pvu_pkg::REG_MODE:    return {{27{mode_cfg[4]}}, mode_cfg};
      default:              return 32'd0;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // register write: setup cycle, then access cycle, then read back
  task automatic write_register(input pvu_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      pvu_pkg::REG_GRAVITY: gravity_cfg = value[15:0];
      pvu_pkg::REG_RADIUS:  radius_cfg  = value[30:0];
      pvu_pkg::REG_ROOM:    room_cfg    = value[30:0];
      pvu_pkg::REG_ATT_X:   att_x_cfg   = value;
      pvu_pkg::REG_ATT_Y:   att_y_cfg   = value;
      pvu_pkg::REG_HALF:    half_cfg    = value[25:0];
      pvu_pkg::REG_MODE:    mode_cfg    = value[4:0];
      default: ;
    endcase
    check_field("prdata", shadow_read(idx), prdata);
    check_field("pready", 32'd1, {31'd0, pready});
  endtask

  // send one particle beat; valid stays up for a back-to-back follower
  task automatic offer_particle(input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] sx, input logic [31:0] sy);
    int gap;
    gap = idle_cycles(send_style);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pos_x   <= px;
    in_pos_y   <= py;
    in_speed_x <= sx;
    in_speed_y <= sy;
    do @(posedge clk); while (!in_ready);
    pending_updates.push_back(euler_step(px, py, sx, sy));
  endtask

  // drop valid and wait until every pending update has come back
  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // result side: random stalls, optional long hold, field compare
  initial begin : result_monitor
    particle_t want;
    int        stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      stall = idle_cycles(recv_style);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_updates.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, actual pos %h %h", $time,
                 out_new_pos_x, out_new_pos_y);
        mismatch_count++;
      end else begin
        want = pending_updates.pop_front();
        check_field("new_pos_x", want.pos_x, out_new_pos_x);
        check_field("new_pos_y", want.pos_y, out_new_pos_y);
        check_field("new_speed_x", want.spd_x, out_new_speed_x);
        check_field("new_speed_y", want.spd_y, out_new_speed_y);
        check_field("wall_hit_x", {31'd0, want.hit_x}, {31'd0, out_wall_hit_x});
        check_field("wall_hit_y", {31'd0, want.hit_y}, {31'd0, out_wall_hit_y});
      end
    end
  end

  // reset settings: field extremes and both walls of the default room
  task automatic test_reset_walls();
    settle_pipeline();
    offer_particle(32'd0, 32'd0, 32'd0, 32'd0);
    offer_particle(32'd2097152, 32'd2097152, 32'd0, 32'd0);
    offer_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0);
    offer_particle(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    offer_particle(32'd2097152, 32'd2097152, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    offer_particle(32'd2097152, 32'd2097152, 32'h8000_0000, 32'h8000_0000);
    // exactly on the walls: not clamped
    offer_particle(32'd4161536, 32'd32768, 32'd0, 32'd0);
    // one step past each wall
    offer_particle(32'd4161537, 32'd4161537, 32'd0, 32'd0);
    offer_particle(32'd32767, 32'd32767, 32'd0, 32'd0);
    settle_pipeline();
  endtask

  // attractor box bounds, gain extremes, degenerate and wrapping rooms
  task automatic test_config_corners();
    settle_pipeline();
    write_register(pvu_pkg::REG_GRAVITY, 32'h0000_FFFF);
    write_register(pvu_pkg::REG_MODE, 32'd8);
    write_register(pvu_pkg::REG_ATT_X, 32'd2097152);
    write_register(pvu_pkg::REG_ATT_Y, 32'd2097152);
    write_register(pvu_pkg::REG_HALF, 32'd655);
    // offsets of +half and -half are inside, one more is outside
    offer_particle(32'd2097152 - 32'd655, 32'd2097152 + 32'd655, 32'h0000_1000, 32'h0000_1000);
    offer_particle(32'd2097152 - 32'd656, 32'd2097152, 32'h0000_1000, 32'h0000_1000);
    offer_particle(32'd2097152, 32'd2097152 + 32'd656, 32'h0000_1000, 32'h0000_1000);
    offer_particle(32'd2097152 + 32'd655, 32'd2097152 - 32'd655, 32'd0, 32'h8000_0000);
    settle_pipeline();

    write_register(pvu_pkg::REG_GRAVITY, 32'd0);
    write_register(pvu_pkg::REG_HALF, 32'd65536000);
    write_register(pvu_pkg::REG_MODE, 32'h0000_0018);
    write_register(pvu_pkg::REG_ATT_X, 32'h7FFF_FFFF);
    write_register(pvu_pkg::REG_ATT_Y, 32'h8000_0000);
    offer_particle(32'h7FFF_FFFF - 32'd1000, 32'h8000_0000 + 32'd1000, 32'd5000, 32'hFFFF_0000);
    offer_particle(32'd0, 32'd0, 32'd0, 32'd0);
    settle_pipeline();

    // gains beyond the nominal range
    write_register(pvu_pkg::REG_ATT_X, 32'd2097152);
    write_register(pvu_pkg::REG_ATT_Y, 32'd2097152);
    write_register(pvu_pkg::REG_MODE, 32'h0000_0010);
    offer_particle(32'd2000000, 32'd2200000, 32'd0, 32'd0);
    settle_pipeline();
    write_register(pvu_pkg::REG_MODE, 32'h0000_000F);
    offer_particle(32'd2200000, 32'd2000000, 32'd0, 32'd0);
    settle_pipeline();

    // room smaller than the ball: high wall wins, clamped values wrap
    write_register(pvu_pkg::REG_MODE, 32'd0);
    write_register(pvu_pkg::REG_RADIUS, 32'h7FFF_FFFF);
    write_register(pvu_pkg::REG_ROOM, 32'd0);
    offer_particle(32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
    offer_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0);
    settle_pipeline();

    // widest room, zero radius
    write_register(pvu_pkg::REG_RADIUS, 32'd0);
    write_register(pvu_pkg::REG_ROOM, 32'h7FFF_FFFF);
    offer_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    offer_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    settle_pipeline();
  endtask

  // random register settings, mostly sane rooms around the attractor
  task automatic program_random_setup();
    logic [31:0] radius;
    logic [31:0] room;
    logic [31:0] half;
    logic [31:0] mode;
    case ($urandom_range(0, 3))
      0:       write_register(pvu_pkg::REG_GRAVITY, 32'd0);
      1:       write_register(pvu_pkg::REG_GRAVITY, 32'h0000_FFFF);
      default: write_register(pvu_pkg::REG_GRAVITY, $urandom_range(0, 16'hFFFF));
    endcase
    radius = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1 << 18) : ($urandom & 32'h7FFF_FFFF);
    room = ($urandom_range(0, 3) != 0) ? 2 * radius + $urandom_range(0, 1 << 24) : $urandom;
    write_register(pvu_pkg::REG_RADIUS, radius & 32'h7FFF_FFFF);
    write_register(pvu_pkg::REG_ROOM, room & 32'h7FFF_FFFF);
    write_register(pvu_pkg::REG_ATT_X, ($urandom_range(0, 4) != 0) ? in_room() : $urandom);
    write_register(pvu_pkg::REG_ATT_Y, ($urandom_range(0, 4) != 0) ? in_room() : $urandom);
    case ($urandom_range(0, 9))
      0:          half = $urandom & 32'h03FF_FFFF;
      1, 2, 3:    half = $urandom_range(655, 65536000);
      default:    half = $urandom_range(655, 1 << 22);
    endcase
    write_register(pvu_pkg::REG_HALF, half);
    mode = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(0, 31);
    write_register(pvu_pkg::REG_MODE, mode);
  endtask

  // random phases, each with its own settings and idle pattern
  task automatic test_random_sweep();
    logic [31:0] px, py;
    int          count;
    int          pick;
    for (int phase = 0; phase < 12; phase++) begin
      settle_pipeline();
      program_random_setup();
      send_style = $urandom_range(0, 2);
      recv_style = $urandom_range(0, 2);
      count = $urandom_range(90, 150);
      repeat (count) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          px = in_room();
          py = in_room();
        end else if (pick < 85) begin
          px = near(att_x_cfg, {6'd0, half_cfg} + 32'd16);
          py = near(att_y_cfg, {6'd0, half_cfg} + 32'd16);
        end else begin
          px = $urandom;
          py = $urandom;
        end
        offer_particle(px, py, random_speed(), random_speed());
      end
    end
    settle_pipeline();
  endtask

  // long output stall with the sender pushing flat out
  task automatic test_output_backpressure();
    settle_pipeline();
    program_random_setup();
    send_style = 0;
    recv_style = 0;
    hold_request = 300;
    repeat (48) offer_particle(in_room(), in_room(), random_speed(), random_speed());
    settle_pipeline();
    send_style = 1;
    recv_style = 1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_walls();
    test_config_corners();
    test_random_sweep();
    test_output_backpressure();
    settle_pipeline();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_updates.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
